// File: rtl/tsb_pkg.sv
// ---------------------------------------------------------------------------
// tsb_pkg
// shared types, codes and helpers of the timer slot bank
// ---------------------------------------------------------------------------
package tsb_pkg;

   localparam int SLOTS     = 16;
   localparam int OUT_LIMIT = 16;

   localparam int MODE_W   = 3;
   localparam int SLOT_W   = 4;
   localparam int TIME_W   = 32;
   localparam int OPT_W    = 2;
   localparam int TAG_W    = 16;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam int CNT_W = $clog2(OUT_LIMIT + 1);

   // request modes
   localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CREATE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_START  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_STOP   = 3'd4;

   // create options
   localparam logic [OPT_W-1:0] OPT_PERIODIC = 2'd0;
   localparam logic [OPT_W-1:0] OPT_ONE_SHOT = 2'd1;

   // stop options
   localparam logic [OPT_W-1:0] STOP_SILENT     = 2'd0;
   localparam logic [OPT_W-1:0] STOP_STORED_TAG = 2'd1;
   localparam logic [OPT_W-1:0] STOP_GIVEN_TAG  = 2'd2;
   localparam logic [OPT_W-1:0] STOP_INVALID    = 2'd3;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_BAD_OPTION  = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD_PERIOD  = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_BAD_DELAY   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NONE_FREE   = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_INACTIVE    = 3'd5;
   localparam logic [STATUS_W-1:0] STAT_NOT_STARTED = 3'd6;

   typedef enum logic [1:0] {
      SLOT_UNUSED  = 2'd0,
      SLOT_USED    = 2'd1,
      SLOT_RUNNING = 2'd2,
      SLOT_STOPPED = 2'd3
   } slot_state_type;

   // request broadcast to every cell
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] delay;
      logic [TIME_W-1:0] period;
      logic              periodic;
      logic              notify;
      logic [TAG_W-1:0]  tag;
      logic              create_ok;
      logic [TIME_W-1:0] time_now;
   } tsb_cmd_type;

   // report of the cell holding the token, zero elsewhere
   typedef struct packed {
      logic             sel;
      logic             fire;
      logic             claim;
      slot_state_type   state;
      logic             notify;
      logic [TAG_W-1:0] tag;
   } tsb_rpt_type;

   function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] idx);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(idx);
      return wide[SLOT_W-1:0];
   endfunction

endpackage

// File: rtl/tsb_cell.sv
// ---------------------------------------------------------------------------
// tsb_cell
// one timer slot of the chain: holds its slot state and acts on the token
// ---------------------------------------------------------------------------
module tsb_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tsb_pkg::IDX_W-1:0]       cell_index,
   input  logic                            shift,
   input  logic                            advance,
   input  logic                            token_in,
   output logic                            token_out,
   input  logic                            got_in,
   output logic                            got_out,
   input  tsb_pkg::tsb_cmd_type            cmd,
   output tsb_pkg::tsb_rpt_type            rpt
);

   logic                           token_ff;
   logic                           got_ff;
   tsb_pkg::slot_state_type        state_ff, state_in;
   logic [tsb_pkg::TIME_W-1:0]     match_ff, match_in;
   logic [tsb_pkg::TIME_W-1:0]     period_ff, period_in;
   logic [tsb_pkg::TIME_W-1:0]     delay_ff, delay_in;
   logic                           periodic_ff, periodic_in;
   logic                           notify_ff, notify_in;
   logic [tsb_pkg::TAG_W-1:0]      tag_ff, tag_in;

   logic acting;
   logic addressed;
   logic claim;
   logic fire;

   assign acting    = token_ff && advance;
   assign addressed = (tsb_pkg::CMP_W'(cell_index) == tsb_pkg::CMP_W'(cmd.slot));

   always_comb begin
      state_in    = state_ff;
      match_in    = match_ff;
      period_in   = period_ff;
      delay_in    = delay_ff;
      periodic_in = periodic_ff;
      notify_in   = notify_ff;
      tag_in      = tag_ff;
      claim       = 1'b0;
      fire        = 1'b0;
      if (acting) begin
         case (cmd.mode)
            tsb_pkg::MODE_TICK: begin
               if (state_ff == tsb_pkg::SLOT_RUNNING && match_ff == cmd.time_now) begin
                  fire = 1'b1;
                  if (periodic_ff) begin
                     match_in = cmd.time_now + period_ff;
                  end else begin
                     state_in = tsb_pkg::SLOT_STOPPED;
                  end
               end
            end
            tsb_pkg::MODE_CREATE: begin
               if (cmd.create_ok && !got_ff && state_ff == tsb_pkg::SLOT_UNUSED) begin
                  claim       = 1'b1;
                  state_in    = tsb_pkg::SLOT_USED;
                  period_in   = cmd.period;
                  delay_in    = cmd.delay;
                  periodic_in = cmd.periodic;
                  notify_in   = cmd.notify;
                  tag_in      = cmd.tag;
               end
            end
            tsb_pkg::MODE_DELETE: begin
               if (addressed && state_ff != tsb_pkg::SLOT_UNUSED) begin
                  state_in = tsb_pkg::SLOT_UNUSED;
               end
            end
            tsb_pkg::MODE_START: begin
               if (addressed && state_ff != tsb_pkg::SLOT_UNUSED) begin
                  match_in = cmd.time_now + (periodic_ff ? period_ff : delay_ff);
                  state_in = tsb_pkg::SLOT_RUNNING;
               end
            end
            tsb_pkg::MODE_STOP: begin
               if (addressed && state_ff == tsb_pkg::SLOT_RUNNING) begin
                  state_in = tsb_pkg::SLOT_STOPPED;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign token_out = token_ff;
   assign got_out   = got_ff || claim;

   assign rpt.sel    = acting && addressed;
   assign rpt.fire   = fire && notify_ff;
   assign rpt.claim  = claim;
   assign rpt.state  = (acting && addressed) ? state_ff : tsb_pkg::SLOT_UNUSED;
   assign rpt.notify = acting && notify_ff;
   assign rpt.tag    = acting ? tag_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= 1'b0;
         got_ff   <= 1'b0;
         state_ff <= tsb_pkg::SLOT_UNUSED;
      end else begin
         if (shift) begin
            token_ff <= token_in;
            got_ff   <= got_in;
         end
         state_ff <= state_in;
      end
   end

   // timer payload, undefined until written by create or start
   always_ff @(posedge clock) begin
      match_ff    <= match_in;
      period_ff   <= period_in;
      delay_ff    <= delay_in;
      periodic_ff <= periodic_in;
      notify_ff   <= notify_in;
      tag_ff      <= tag_in;
   end

endmodule

// File: rtl/timer_slot_bank_unit.sv
// ---------------------------------------------------------------------------
// timer_slot_bank_unit
// bank of software timers held in a chain of slot cells
// ---------------------------------------------------------------------------
// a request is loaded, walks the token one step per slot, then finishes; a stop
//    that sends a notification gives it ahead of its status in the finish state
// a new request is taken only once the last one is done; an unknown mode
//    skips the slot walk
// a stalled result channel pauses the token walk
// reset: synchronous; time count zero, all slots unused, no clearing pass
// ---------------------------------------------------------------------------
module timer_slot_bank_unit (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tsb_pkg::MODE_W-1:0]      req_mode,
   input  logic [tsb_pkg::SLOT_W-1:0]      req_slot,
   input  logic [tsb_pkg::TIME_W-1:0]      req_delay,
   input  logic [tsb_pkg::TIME_W-1:0]      req_period,
   input  logic [tsb_pkg::OPT_W-1:0]       req_option,
   input  logic                            req_notify_enable,
   input  logic [tsb_pkg::TAG_W-1:0]       req_tag,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tsb_pkg::KIND_W-1:0]      rsp_event_kind,
   output logic [tsb_pkg::SLOT_W-1:0]      rsp_slot_out,
   output logic [tsb_pkg::TAG_W-1:0]       rsp_tag_out,
   output logic [tsb_pkg::STATUS_W-1:0]    rsp_status,
   output logic                            rsp_last
);

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_SCAN,
      CTL_FINISH
   } ctl_state_type;

   localparam logic [tsb_pkg::IDX_W-1:0] LAST_IDX = tsb_pkg::IDX_W'(tsb_pkg::SLOTS - 1);
   localparam logic [tsb_pkg::CNT_W-1:0] EV_LIMIT = tsb_pkg::CNT_W'(tsb_pkg::OUT_LIMIT);

   ctl_state_type ctl_state_ff, ctl_state_in;

   // latched request
   logic [tsb_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [tsb_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [tsb_pkg::TIME_W-1:0]   delay_ff, delay_in;
   logic [tsb_pkg::TIME_W-1:0]   period_ff, period_in;
   logic [tsb_pkg::OPT_W-1:0]    option_ff, option_in;
   logic                         notify_ff, notify_in;
   logic [tsb_pkg::TAG_W-1:0]    tag_ff, tag_in;

   logic [tsb_pkg::TIME_W-1:0]   time_ff, time_in;
   logic [tsb_pkg::IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [tsb_pkg::CNT_W-1:0]    ev_count_ff, ev_count_in;

   // one event held back so that the final one can carry last
   logic                         pend_valid_ff, pend_valid_in;
   logic [tsb_pkg::KIND_W-1:0]   pend_kind_ff, pend_kind_in;
   logic [tsb_pkg::SLOT_W-1:0]   pend_slot_ff, pend_slot_in;
   logic [tsb_pkg::TAG_W-1:0]    pend_tag_ff, pend_tag_in;

   logic                         found_ff, found_in;
   logic [tsb_pkg::IDX_W-1:0]    found_idx_ff, found_idx_in;
   tsb_pkg::slot_state_type      addr_state_ff, addr_state_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tsb_pkg::KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [tsb_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [tsb_pkg::TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;
   logic [tsb_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         out_free;
   logic                         advance;
   logic                         shift;
   logic                         inject;
   logic                         req_known;
   logic [tsb_pkg::STATUS_W-1:0] create_status;
   logic [tsb_pkg::STATUS_W-1:0] cmd_status;
   logic [tsb_pkg::SLOT_W-1:0]   cmd_slot;

   tsb_pkg::tsb_cmd_type         cmd;
   tsb_pkg::tsb_rpt_type         cell_rpt [tsb_pkg::SLOTS];
   tsb_pkg::tsb_rpt_type         rpt_all;
   logic [tsb_pkg::SLOTS-1:0]    token_vec;
   logic [tsb_pkg::SLOTS-1:0]    claim_vec;
   logic [tsb_pkg::SLOTS:0]      token_chain;
   logic [tsb_pkg::SLOTS:0]      got_chain;

   // the output register frees up when it is empty or being taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (ctl_state_ff != CTL_IDLE);
   assign req_known = (req_mode inside {[tsb_pkg::MODE_TICK:tsb_pkg::MODE_STOP]});

   // a token step may push one held-back event, so it needs the output free
   assign advance = (ctl_state_ff == CTL_SCAN) && out_free;
   assign inject  = req_valid && !req_stall && req_known;
   assign shift   = advance || inject;

   // create checks, ahead of the slot search
   always_comb begin
      if (option_ff > tsb_pkg::OPT_ONE_SHOT) begin
         create_status = tsb_pkg::STAT_BAD_OPTION;
      end else if (option_ff == tsb_pkg::OPT_PERIODIC && period_ff == '0) begin
         create_status = tsb_pkg::STAT_BAD_PERIOD;
      end else if (option_ff == tsb_pkg::OPT_ONE_SHOT && delay_ff == '0) begin
         create_status = tsb_pkg::STAT_BAD_DELAY;
      end else begin
         create_status = tsb_pkg::STAT_OK;
      end
   end

   assign cmd.mode      = mode_ff;
   assign cmd.slot      = slot_ff;
   assign cmd.delay     = delay_ff;
   assign cmd.period    = period_ff;
   assign cmd.periodic  = (option_ff == tsb_pkg::OPT_PERIODIC);
   assign cmd.notify    = notify_ff;
   assign cmd.tag       = tag_ff;
   assign cmd.create_ok = (create_status == tsb_pkg::STAT_OK);
   assign cmd.time_now  = time_ff;

   // chain of slot cells: token and taken-flag walk from slot 0 upwards
   assign token_chain[0] = inject;
   assign got_chain[0]   = 1'b0;

   for (genvar g = 0; g < tsb_pkg::SLOTS; g++) begin : g_cell
      tsb_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (tsb_pkg::IDX_W'(g)),
         .shift      (shift),
         .advance    (advance),
         .token_in   (token_chain[g]),
         .token_out  (token_chain[g+1]),
         .got_in     (got_chain[g]),
         .got_out    (got_chain[g+1]),
         .cmd        (cmd),
         .rpt        (cell_rpt[g])
      );
      assign token_vec[g] = token_chain[g+1];
      assign claim_vec[g] = cell_rpt[g].claim;
   end

   // only the token holder reports, so an or over the row picks it out
   always_comb begin
      rpt_all = '0;
      for (int i = 0; i < tsb_pkg::SLOTS; i++) begin
         rpt_all = tsb_pkg::tsb_rpt_type'(rpt_all | cell_rpt[i]);
      end
   end

   // closing status of the request
   always_comb begin
      cmd_slot = slot_ff;
      case (mode_ff)
         tsb_pkg::MODE_CREATE: begin
            if (create_status != tsb_pkg::STAT_OK) begin
               cmd_status = create_status;
               cmd_slot   = '0;
            end else if (!found_ff) begin
               cmd_status = tsb_pkg::STAT_NONE_FREE;
               cmd_slot   = '0;
            end else begin
               cmd_status = tsb_pkg::STAT_OK;
               cmd_slot   = tsb_pkg::idx_to_slot(found_idx_ff);
            end
         end
         tsb_pkg::MODE_DELETE, tsb_pkg::MODE_START: begin
            cmd_status = (addr_state_ff == tsb_pkg::SLOT_UNUSED) ?
                         tsb_pkg::STAT_INACTIVE : tsb_pkg::STAT_OK;
         end
         tsb_pkg::MODE_STOP: begin
            if (addr_state_ff != tsb_pkg::SLOT_RUNNING) begin
               cmd_status = tsb_pkg::STAT_NOT_STARTED;
            end else if (option_ff == tsb_pkg::STOP_INVALID) begin
               cmd_status = tsb_pkg::STAT_BAD_OPTION;
            end else begin
               cmd_status = tsb_pkg::STAT_OK;
            end
         end
         default: begin
            // unknown mode
            cmd_status = tsb_pkg::STAT_BAD_OPTION;
            cmd_slot   = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      ctl_state_in  = ctl_state_ff;
      mode_in       = mode_ff;
      slot_in       = slot_ff;
      delay_in      = delay_ff;
      period_in     = period_ff;
      option_in     = option_ff;
      notify_in     = notify_ff;
      tag_in        = tag_ff;
      time_in       = time_ff;
      scan_idx_in   = scan_idx_ff;
      ev_count_in   = ev_count_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_slot_in  = pend_slot_ff;
      pend_tag_in   = pend_tag_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      addr_state_in = addr_state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      case (ctl_state_ff)
         CTL_IDLE: begin
            if (req_valid) begin
               mode_in       = req_mode;
               slot_in       = req_slot;
               delay_in      = req_delay;
               period_in     = req_period;
               option_in     = req_option;
               notify_in     = req_notify_enable;
               tag_in        = req_tag;
               scan_idx_in   = '0;
               ev_count_in   = '0;
               pend_valid_in = 1'b0;
               found_in      = 1'b0;
               addr_state_in = tsb_pkg::SLOT_UNUSED;
               if (req_mode == tsb_pkg::MODE_TICK) begin
                  time_in = time_ff + 1'b1;
               end
               ctl_state_in = req_known ? CTL_SCAN : CTL_FINISH;
            end
         end
         CTL_SCAN: begin
            if (advance) begin
               scan_idx_in = scan_idx_ff + 1'b1;
               if (rpt_all.sel) begin
                  addr_state_in = rpt_all.state;
               end
               if (rpt_all.claim) begin
                  found_in     = 1'b1;
                  found_idx_in = scan_idx_ff;
               end
               // fire event; past the limit the slot still updates, event dropped
               if (rpt_all.fire && ev_count_ff < EV_LIMIT) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = pend_kind_ff;
                     rsp_slot_in   = pend_slot_ff;
                     rsp_tag_in    = pend_tag_ff;
                     rsp_status_in = tsb_pkg::STAT_OK;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_kind_in  = tsb_pkg::KIND_FIRE;
                  pend_slot_in  = tsb_pkg::idx_to_slot(scan_idx_ff);
                  pend_tag_in   = rpt_all.tag;
                  ev_count_in   = ev_count_ff + 1'b1;
               end
               // stop notification goes ahead of the status
               if (mode_ff == tsb_pkg::MODE_STOP && rpt_all.sel &&
                   rpt_all.state == tsb_pkg::SLOT_RUNNING && rpt_all.notify &&
                   (option_ff == tsb_pkg::STOP_STORED_TAG ||
                    option_ff == tsb_pkg::STOP_GIVEN_TAG)) begin
                  pend_valid_in = 1'b1;
                  pend_kind_in  = tsb_pkg::KIND_STOP;
                  pend_slot_in  = slot_ff;
                  pend_tag_in   = (option_ff == tsb_pkg::STOP_STORED_TAG) ?
                                  rpt_all.tag : tag_ff;
               end
               if (scan_idx_ff == LAST_IDX) begin
                  ctl_state_in = CTL_FINISH;
               end
            end
         end
         CTL_FINISH: begin
            if (out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = pend_kind_ff;
                  rsp_slot_in   = pend_slot_ff;
                  rsp_tag_in    = pend_tag_ff;
                  rsp_status_in = tsb_pkg::STAT_OK;
                  rsp_last_in   = (mode_ff == tsb_pkg::MODE_TICK);
                  pend_valid_in = 1'b0;
                  if (mode_ff == tsb_pkg::MODE_TICK) begin
                     ctl_state_in = CTL_IDLE;
                  end
               end else if (mode_ff == tsb_pkg::MODE_TICK) begin
                  // tick with no event gives no result
                  ctl_state_in = CTL_IDLE;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = tsb_pkg::KIND_STATUS;
                  rsp_slot_in   = cmd_slot;
                  rsp_tag_in    = '0;
                  rsp_status_in = cmd_status;
                  rsp_last_in   = 1'b1;
                  ctl_state_in  = CTL_IDLE;
               end
            end
         end
         default: begin
            ctl_state_in = CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_state_ff  <= CTL_IDLE;
         time_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
         ev_count_ff   <= '0;
         scan_idx_ff   <= '0;
      end else begin
         ctl_state_ff  <= ctl_state_in;
         time_ff       <= time_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         found_ff      <= found_in;
         ev_count_ff   <= ev_count_in;
         scan_idx_ff   <= scan_idx_in;
         mode_ff       <= mode_in;
         slot_ff       <= slot_in;
         delay_ff      <= delay_in;
         period_ff     <= period_in;
         option_ff     <= option_in;
         notify_ff     <= notify_in;
         tag_ff        <= tag_in;
         pend_kind_ff  <= pend_kind_in;
         pend_slot_ff  <= pend_slot_in;
         pend_tag_ff   <= pend_tag_in;
         found_idx_ff  <= found_idx_in;
         addr_state_ff <= addr_state_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_tag_ff    <= rsp_tag_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_slot_out   = rsp_slot_ff;
   assign rsp_tag_out    = rsp_tag_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

   // at most one cell holds the token
   a_token_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(token_vec))
      else $error("more than one cell holds the token");

   // the token is only in the chain while scanning
   a_token_scan: assert property (@(posedge clock) disable iff (reset)
      (ctl_state_ff != CTL_SCAN) |-> (token_vec == '0))
      else $error("token left in chain outside a scan");

   // a create claims at most one slot per step and only once per request
   a_claim_once: assert property (@(posedge clock) disable iff (reset)
      $onehot0(claim_vec) && !(found_ff && (claim_vec != '0)))
      else $error("slot claimed twice");

   // reported events never pass the limit
   a_event_limit: assert property (@(posedge clock) disable iff (reset)
      ev_count_ff <= EV_LIMIT)
      else $error("event count beyond limit");

   // a result is loaded only when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_kind_ff) &&
                                      $stable(rsp_slot_ff) && $stable(rsp_status_ff)))
      else $error("held result overwritten");

endmodule
